[rtl/elev_pkg.sv]
`default_nettype none

package elev_pkg;

   // Field widths of the item and result transfers.
   localparam int CMD_W   = 3;
   localparam int FLOOR_W = 5;
   localparam int MODE_W  = 3;
   localparam int COUNT_W = 5;

   // Request queue geometry.
   localparam int QDEPTH = 16;
   localparam int QADDR_W = $clog2(QDEPTH);

   // Defaults for the top-level parameters.
   localparam int MAX_FLOORS_DEF     = 16;
   localparam int OBSTACLE_TICKS_DEF = 20;

   // The floor the car parks at on a fire alarm and after reset.
   localparam logic [FLOOR_W-1:0] HOME_FLOOR = FLOOR_W'(1);

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK     = 3'd0,
      CMD_ADD      = 3'd1,
      CMD_FIRE     = 3'd2,
      CMD_OBSTACLE = 3'd3,
      CMD_OPEN     = 3'd4,
      CMD_CLOSE    = 3'd5,
      CMD_RESET    = 3'd6
   } cmd_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_IDLE      = 3'd0,
      MODE_MOVING    = 3'd1,
      MODE_OPENING   = 3'd2,
      MODE_CLOSING   = 3'd3,
      MODE_EMERGENCY = 3'd4
   } mode_type;

   // Controller to datapath.
   typedef struct packed {
      logic latch;    // capture the accepted command
      logic rd_head;  // read the request at the head of the queue
      logic rd_scan;  // read the next queued request for the duplicate search
      logic exec;     // commit the command to the car state
   } ctl_type;

   // Datapath to controller.
   typedef struct packed {
      logic need_head;  // the latched tick must read the request at the head of the queue
      logic need_scan;  // the latched add request must be checked for a duplicate
      logic scan_more;  // queued requests remain to be read by the search
   } stat_type;

endpackage

`default_nettype wire

[rtl/elev_ctrl.sv]
`default_nettype none

module elev_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire elev_pkg::stat_type stat,
   output elev_pkg::ctl_type      ctl,
   output logic                   busy,
   output logic                   rsp_valid
);
   import elev_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_HEAD,
      ST_SCAN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;

   always_comb begin
      ctl      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctl.latch = 1'b1;
               state_in  = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (stat.need_head) begin
               ctl.rd_head = 1'b1;
               state_in    = ST_HEAD;
            end else if (stat.need_scan) begin
               ctl.rd_scan = 1'b1;
               state_in    = ST_SCAN;
            end else begin
               ctl.exec = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_HEAD: begin
            ctl.exec = 1'b1;
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (stat.scan_more) begin
               ctl.rd_scan = 1'b1;
            end else begin
               ctl.exec = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= ctl.exec;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // A result strobe always drops again straight after it is shown.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for two cycles");

   // An accepted command always makes the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted command did not start work");

   // Every commit is followed by a result strobe and a free block.
   a_exec_done: assert property (@(posedge clock) disable iff (reset)
      ctl.exec |=> (rsp_valid_ff && !busy))
      else $error("commit not followed by a result");

endmodule

`default_nettype wire

[rtl/elev_dpath.sv]
`default_nettype none

module elev_dpath #(
   parameter int MAX_FLOORS     = elev_pkg::MAX_FLOORS_DEF,
   parameter int OBSTACLE_TICKS = elev_pkg::OBSTACLE_TICKS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire elev_pkg::ctl_type           ctl,
   input  wire logic [elev_pkg::CMD_W-1:0]   req_cmd,
   input  wire logic [elev_pkg::FLOOR_W-1:0] req_request_floor,
   output elev_pkg::stat_type               stat,
   output logic [elev_pkg::FLOOR_W-1:0]      rsp_current_floor,
   output logic [elev_pkg::MODE_W-1:0]       rsp_car_mode,
   output logic [elev_pkg::COUNT_W-1:0]      rsp_pending_count,
   output logic                             rsp_fire_lock,
   output logic                             rsp_obstacle_active,
   output logic                             rsp_request_accepted
);
   import elev_pkg::*;

   localparam int OBS_W = $clog2(OBSTACLE_TICKS + 1);
   localparam logic [OBS_W-1:0] OBS_LOAD = OBS_W'(OBSTACLE_TICKS);
   localparam logic [FLOOR_W+1:0] TOP_FLOOR = (FLOOR_W+2)'(MAX_FLOORS);
   localparam logic [COUNT_W-1:0] QFULL = COUNT_W'(QDEPTH);

   logic [FLOOR_W-1:0] queue_mem [QDEPTH];

   logic [CMD_W-1:0]   cmd_ff;
   logic [FLOOR_W-1:0] req_floor_ff;
   logic [COUNT_W-1:0] idx_ff, idx_in;
   logic               cmp_vld_ff;
   logic               hit_ff, hit_in;
   logic [FLOOR_W-1:0] rd_data_ff;

   logic [QADDR_W-1:0] head_ff, head_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [FLOOR_W-1:0] floor_ff, floor_in;
   mode_type           mode_ff, mode_in;
   logic               fire_ff, fire_in;
   logic               obs_ff, obs_in;
   logic [OBS_W-1:0]   oticks_ff, oticks_in;
   logic               acc_ff, acc_in;

   logic [QADDR_W-1:0] rd_addr;
   logic [QADDR_W-1:0] wr_addr;
   logic               wr_en;
   logic               floor_ok;
   logic               dup;
   logic [FLOOR_W-1:0] step_floor;

   assign rd_addr  = ctl.rd_head ? head_ff : head_ff + idx_ff[QADDR_W-1:0];
   assign wr_addr  = head_ff + count_ff[QADDR_W-1:0];
   assign floor_ok = (req_floor_ff != '0) && ({2'b00, req_floor_ff} <= TOP_FLOOR);
   assign hit_in   = hit_ff || (cmp_vld_ff && (rd_data_ff == req_floor_ff));
   assign dup      = hit_in;
   assign idx_in   = ctl.rd_scan ? idx_ff + COUNT_W'(1) : idx_ff;

   assign stat.need_head = (cmd_ff == CMD_TICK) && !fire_ff && !obs_ff && (count_ff != '0)
                           && ((mode_ff == MODE_IDLE) || (mode_ff == MODE_MOVING));
   assign stat.need_scan = (cmd_ff == CMD_ADD) && floor_ok && (count_ff != '0)
                           && (count_ff != QFULL);
   assign stat.scan_more = (idx_ff != count_ff);

   // One floor toward the request at the head of the queue.
   always_comb begin
      if (rd_data_ff > floor_ff) begin
         step_floor = floor_ff + FLOOR_W'(1);
      end else if (rd_data_ff < floor_ff) begin
         step_floor = floor_ff - FLOOR_W'(1);
      end else begin
         step_floor = floor_ff;
      end
   end

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      floor_in  = floor_ff;
      mode_in   = mode_ff;
      fire_in   = fire_ff;
      obs_in    = obs_ff;
      oticks_in = oticks_ff;
      acc_in    = acc_ff;
      wr_en     = 1'b0;
      if (ctl.exec) begin
         acc_in = 1'b0;
         case (cmd_ff)
            CMD_TICK: begin
               if (!fire_ff) begin
                  if (obs_ff) begin
                     if (oticks_ff != '0) begin
                        oticks_in = oticks_ff - OBS_W'(1);
                        if (oticks_ff == OBS_W'(1)) begin
                           obs_in  = 1'b0;
                           mode_in = MODE_IDLE;
                        end
                     end
                  end else if (count_ff == '0) begin
                     mode_in = MODE_IDLE;
                  end else if ((mode_ff == MODE_IDLE) || (mode_ff == MODE_MOVING)) begin
                     mode_in  = MODE_MOVING;
                     floor_in = step_floor;
                     if (step_floor == rd_data_ff) begin
                        head_in  = head_ff + QADDR_W'(1);
                        count_in = count_ff - COUNT_W'(1);
                     end
                  end
               end
            end
            CMD_ADD: begin
               if (floor_ok && (count_ff != QFULL) && !dup) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + COUNT_W'(1);
                  acc_in   = 1'b1;
               end
            end
            CMD_FIRE: begin
               mode_in  = MODE_EMERGENCY;
               fire_in  = 1'b1;
               floor_in = HOME_FLOOR;
            end
            CMD_OBSTACLE: begin
               if (mode_ff == MODE_CLOSING) begin
                  obs_in    = 1'b1;
                  oticks_in = OBS_LOAD;
                  mode_in   = MODE_EMERGENCY;
               end
            end
            CMD_OPEN: begin
               mode_in = MODE_OPENING;
            end
            CMD_CLOSE: begin
               mode_in = MODE_CLOSING;
            end
            CMD_RESET: begin
               head_in   = '0;
               count_in  = '0;
               floor_in  = HOME_FLOOR;
               mode_in   = MODE_IDLE;
               fire_in   = 1'b0;
               obs_in    = 1'b0;
               oticks_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         queue_mem[wr_addr] <= req_floor_ff;
      end
      if (ctl.rd_head || ctl.rd_scan) begin
         rd_data_ff <= queue_mem[rd_addr];
      end
      if (ctl.latch) begin
         cmd_ff       <= req_cmd;
         req_floor_ff <= req_request_floor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= '0;
         cmp_vld_ff <= 1'b0;
         hit_ff     <= 1'b0;
         head_ff    <= '0;
         count_ff   <= '0;
         floor_ff   <= HOME_FLOOR;
         mode_ff    <= MODE_IDLE;
         fire_ff    <= 1'b0;
         obs_ff     <= 1'b0;
         oticks_ff  <= '0;
         acc_ff     <= 1'b0;
      end else begin
         idx_ff     <= ctl.latch ? '0 : idx_in;
         cmp_vld_ff <= ctl.rd_scan;
         hit_ff     <= ctl.latch ? 1'b0 : hit_in;
         head_ff    <= head_in;
         count_ff   <= count_in;
         floor_ff   <= floor_in;
         mode_ff    <= mode_in;
         fire_ff    <= fire_in;
         obs_ff     <= obs_in;
         oticks_ff  <= oticks_in;
         acc_ff     <= acc_in;
      end
   end

   assign rsp_current_floor    = floor_ff;
   assign rsp_car_mode         = mode_ff;
   assign rsp_pending_count    = count_ff;
   assign rsp_fire_lock        = fire_ff;
   assign rsp_obstacle_active  = obs_ff;
   assign rsp_request_accepted = acc_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QFULL)
      else $error("request queue count beyond its depth");

   // The fire lock keeps the car parked at the home floor.
   a_fire_home: assert property (@(posedge clock) disable iff (reset)
      fire_ff |-> (floor_ff == HOME_FLOOR))
      else $error("car left the home floor under fire lock");

   // The obstacle flag is never set while its countdown is empty.
   a_obs_count: assert property (@(posedge clock) disable iff (reset)
      obs_ff |-> (oticks_ff != '0))
      else $error("obstacle flag set with an empty countdown");

endmodule

`default_nettype wire

[rtl/elevator_car_controller.sv]
// Elevator car controller: one command transfer in, one result transfer out.
// The result strobe is registered from the commit. Most commands commit right after
// they are decoded; a tick that moves the car first reads the head request, and an
// add request is first checked against each queued request in turn.
// Throughput: a new command can be accepted in the cycle the result is shown.
// Reset is synchronous; the receiver cannot stall and takes each result at once.
`default_nettype none

module elevator_car_controller #(
   parameter int MAX_FLOORS     = elev_pkg::MAX_FLOORS_DEF,
   parameter int OBSTACLE_TICKS = elev_pkg::OBSTACLE_TICKS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [elev_pkg::CMD_W-1:0]   req_cmd,
   input  wire logic [elev_pkg::FLOOR_W-1:0] req_request_floor,
   output logic                             rsp_valid,
   output logic [elev_pkg::FLOOR_W-1:0]      rsp_current_floor,
   output logic [elev_pkg::MODE_W-1:0]       rsp_car_mode,
   output logic [elev_pkg::COUNT_W-1:0]      rsp_pending_count,
   output logic                             rsp_fire_lock,
   output logic                             rsp_obstacle_active,
   output logic                             rsp_request_accepted
);
   import elev_pkg::*;

   // The controller sequences each command: it captures the transfer, then
   // either commits at once, reads the head request for a moving tick, or
   // walks the queue one entry per cycle to reject a duplicate request.
   // The datapath holds the queue memory and the car state. The car state
   // registers also drive the result ports, so a result stays valid while
   // the next command is being taken in.
   ctl_type  ctl;
   stat_type stat;

   elev_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .ctl       (ctl),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   elev_dpath #(
      .MAX_FLOORS     (MAX_FLOORS),
      .OBSTACLE_TICKS (OBSTACLE_TICKS)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .ctl                  (ctl),
      .req_cmd              (req_cmd),
      .req_request_floor    (req_request_floor),
      .stat                 (stat),
      .rsp_current_floor    (rsp_current_floor),
      .rsp_car_mode         (rsp_car_mode),
      .rsp_pending_count    (rsp_pending_count),
      .rsp_fire_lock        (rsp_fire_lock),
      .rsp_obstacle_active  (rsp_obstacle_active),
      .rsp_request_accepted (rsp_request_accepted)
   );

endmodule

`default_nettype wire

[sim/elev_checker.sv]
module elev_checker (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic                         busy,
   input  wire logic [elev_pkg::CMD_W-1:0]   req_cmd,
   input  wire logic [elev_pkg::FLOOR_W-1:0] req_request_floor,
   input  wire logic                         rsp_valid,
   input  wire logic [elev_pkg::FLOOR_W-1:0] rsp_current_floor,
   input  wire logic [elev_pkg::MODE_W-1:0]  rsp_car_mode,
   input  wire logic [elev_pkg::COUNT_W-1:0] rsp_pending_count,
   input  wire logic                         rsp_fire_lock,
   input  wire logic                         rsp_obstacle_active,
   input  wire logic                         rsp_request_accepted,
   output int unsigned                       mismatch_total,
   output int unsigned                       results_total,
   output int unsigned                       awaited_total
);
   timeunit 1ns;
   timeprecision 1ps;

   import elev_pkg::*;

   typedef struct packed {
      logic [FLOOR_W-1:0] floor;
      logic [MODE_W-1:0]  mode;
      logic [COUNT_W-1:0] pending;
      logic               fire;
      logic               obstacle;
      logic               accepted;
   } car_status_type;

   // Private copy of the car: request ring, position, mode and lock flags.
   logic [FLOOR_W-1:0] slot_floor [QDEPTH];
   logic [QADDR_W-1:0] slot_head;
   logic [COUNT_W-1:0] slot_count;
   logic [FLOOR_W-1:0] car_floor;
   mode_type           car_mode;
   logic               fire_lock_on;
   logic               obstacle_on;
   int unsigned        obstacle_left;

   car_status_type awaited_status[$];
   int unsigned    mismatches = 0;
   int unsigned    results = 0;

   function automatic void clear_car();
      slot_head     = '0;
      slot_count    = '0;
      car_floor     = HOME_FLOOR;
      car_mode      = MODE_IDLE;
      fire_lock_on  = 1'b0;
      obstacle_on   = 1'b0;
      obstacle_left = 0;
   endfunction

   function automatic logic floor_queued(input logic [FLOOR_W-1:0] floor);
      logic [QADDR_W-1:0] idx;
      for (int i = 0; i < slot_count; i++) begin
         idx = slot_head + QADDR_W'(i);
         if (slot_floor[idx] == floor) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic try_enqueue(input logic [FLOOR_W-1:0] floor);
      logic [QADDR_W-1:0] tail;
      if (floor < 1 || floor > MAX_FLOORS_DEF) return 1'b0;
      if (slot_count >= QDEPTH || floor_queued(floor)) return 1'b0;
      tail = slot_head + slot_count[QADDR_W-1:0];
      slot_floor[tail] = floor;
      slot_count++;
      return 1'b1;
   endfunction

   // A tick is frozen by the fire lock, then spent on the obstacle countdown, and
   // only otherwise moves an idle or moving car one floor toward the head request.
   function automatic void step_tick();
      logic [FLOOR_W-1:0] target;
      if (fire_lock_on) return;
      if (obstacle_on) begin
         if (obstacle_left > 0) begin
            obstacle_left--;
            if (obstacle_left == 0) begin
               obstacle_on = 1'b0;
               car_mode    = MODE_IDLE;
            end
         end
         return;
      end
      if (slot_count == 0) begin
         car_mode = MODE_IDLE;
         return;
      end
      if (car_mode == MODE_IDLE) car_mode = MODE_MOVING;
      if (car_mode == MODE_MOVING) begin
         target = slot_floor[slot_head];
         if (target > car_floor) car_floor++;
         else if (target < car_floor) car_floor--;
         if (car_floor == target) begin
            slot_head++;
            slot_count--;
         end
      end
   endfunction

   function automatic car_status_type advance_car(input logic [CMD_W-1:0]   cmd,
                                                  input logic [FLOOR_W-1:0] floor);
      car_status_type s;
      logic           taken;
      taken = 1'b0;
      case (cmd)
         CMD_TICK: step_tick();
         CMD_ADD: taken = try_enqueue(floor);
         CMD_FIRE: begin
            car_mode     = MODE_EMERGENCY;
            fire_lock_on = 1'b1;
            car_floor    = HOME_FLOOR;
         end
         CMD_OBSTACLE: begin
            if (car_mode == MODE_CLOSING) begin
               obstacle_on   = 1'b1;
               obstacle_left = OBSTACLE_TICKS_DEF;
               car_mode      = MODE_EMERGENCY;
            end
         end
         CMD_OPEN: car_mode = MODE_OPENING;
         CMD_CLOSE: car_mode = MODE_CLOSING;
         CMD_RESET: clear_car();
         default: ;
      endcase
      s.floor    = car_floor;
      s.mode     = car_mode;
      s.pending  = slot_count;
      s.fire     = fire_lock_on;
      s.obstacle = obstacle_on;
      s.accepted = taken;
      return s;
   endfunction

   always @(posedge clock) begin
      car_status_type seen;
      car_status_type due;
      if (reset) begin
         clear_car();
         awaited_status.delete();
      end else begin
         // Results are compared before this edge's command is predicted.
         if (rsp_valid) begin
            seen = {rsp_current_floor, rsp_car_mode, rsp_pending_count,
                    rsp_fire_lock, rsp_obstacle_active, rsp_request_accepted};
            results++;
            if (awaited_status.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result with no command outstanding", $time);
            end else begin
               due = awaited_status.pop_front();
               if (seen !== due) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"%0t: expected floor=%0d mode=%0d pending=%0d fire=%0b ",
                               "obstacle=%0b accepted=%0b, got floor=%0d mode=%0d ",
                               "pending=%0d fire=%0b obstacle=%0b accepted=%0b"},
                              $time, due.floor, due.mode, due.pending, due.fire,
                              due.obstacle, due.accepted, seen.floor, seen.mode,
                              seen.pending, seen.fire, seen.obstacle, seen.accepted);
               end
            end
         end
         if (start && !busy)
            awaited_status.push_back(advance_car(req_cmd, req_request_floor));
      end
      mismatch_total <= mismatches;
      results_total  <= results;
      awaited_total  <= awaited_status.size();
   end

endmodule

[sim/tb_top.sv]
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import elev_pkg::*;

   // Command code that the block has no meaning for; it must change nothing.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

   // Roughly how many commands the run sends before it drains.
   localparam int unsigned ITEM_TARGET = 950;
   // The limit lies far above what even a run well past the target needs, with the
   // slowest commands and the longest sender gaps.
   localparam int unsigned CYCLE_LIMIT = 400000;
   // Longest latency of the block plus a margin, waited out after the drain.
   localparam int unsigned DRAIN_CYCLES = 24;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic [CMD_W-1:0]   req_cmd = '0;
   logic [FLOOR_W-1:0] req_request_floor = '0;

   wire logic               busy;
   wire logic               rsp_valid;
   wire logic [FLOOR_W-1:0] rsp_current_floor;
   wire logic [MODE_W-1:0]  rsp_car_mode;
   wire logic [COUNT_W-1:0] rsp_pending_count;
   wire logic               rsp_fire_lock;
   wire logic               rsp_obstacle_active;
   wire logic               rsp_request_accepted;

   int unsigned mismatch_total;
   int unsigned results_total;
   int unsigned awaited_total;

   int unsigned cycle_count = 0;
   int unsigned burst_left = 0;
   int unsigned sent_total = 0;
   int unsigned sent_by_cmd [8] = '{default: 0};

   elevator_car_controller i_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_cmd              (req_cmd),
      .req_request_floor    (req_request_floor),
      .rsp_valid            (rsp_valid),
      .rsp_current_floor    (rsp_current_floor),
      .rsp_car_mode         (rsp_car_mode),
      .rsp_pending_count    (rsp_pending_count),
      .rsp_fire_lock        (rsp_fire_lock),
      .rsp_obstacle_active  (rsp_obstacle_active),
      .rsp_request_accepted (rsp_request_accepted)
   );

   // The checker watches both channels, predicts every result and reports
   // how many results differed and how many are still awaited.
   elev_checker i_checker (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_cmd              (req_cmd),
      .req_request_floor    (req_request_floor),
      .rsp_valid            (rsp_valid),
      .rsp_current_floor    (rsp_current_floor),
      .rsp_car_mode         (rsp_car_mode),
      .rsp_pending_count    (rsp_pending_count),
      .rsp_fire_lock        (rsp_fire_lock),
      .rsp_obstacle_active  (rsp_obstacle_active),
      .rsp_request_accepted (rsp_request_accepted),
      .mismatch_total       (mismatch_total),
      .results_total        (results_total),
      .awaited_total        (awaited_total)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Watchdog: a hung handshake or a missing result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Cycle limit of %0d reached with %0d results outstanding.",
                  CYCLE_LIMIT, awaited_total);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Any 5-bit value; most commands ignore the floor, so it is random there.
   function automatic logic [FLOOR_W-1:0] any_floor();
      return FLOOR_W'($urandom_range(0, 31));
   endfunction

   function automatic logic [FLOOR_W-1:0] valid_floor();
      return FLOOR_W'($urandom_range(1, MAX_FLOORS_DEF));
   endfunction

   // Sends one command and returns at the edge where its transfer happens.
   // The sender works in bursts of random length; a burst may open with an
   // idle gap, during which start is low. Within a burst start stays high
   // from one transfer to the next, so it never gets two updates in a step.
   task automatic send_command(input logic [CMD_W-1:0]   cmd,
                               input logic [FLOOR_W-1:0] floor);
      int unsigned gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 10);
      end
      burst_left--;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start             <= 1'b1;
      req_cmd           <= cmd;
      req_request_floor <= floor;
      do @(posedge clock); while (busy);
      sent_total++;
      sent_by_cmd[cmd]++;
   endtask

   task automatic run_ticks(input int unsigned count);
      repeat (count) send_command(CMD_TICK, any_floor());
   endtask

   initial begin
      int unsigned        pick;
      int unsigned        ticks;
      int unsigned        j;
      logic [FLOOR_W-1:0] swap;
      logic [FLOOR_W-1:0] order [MAX_FLOORS_DEF];

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Floor requests at the top floor, at zero, with every
      // bit set and just past the top; a duplicate; a request for the floor
      // the car is already at.
      send_command(CMD_ADD, 5'd16);
      send_command(CMD_ADD, 5'd16);
      send_command(CMD_ADD, 5'd0);
      send_command(CMD_ADD, 5'd31);
      send_command(CMD_ADD, 5'd17);
      send_command(CMD_ADD, 5'd1);
      // The first tick turns an idle car into a moving one and takes a step.
      send_command(CMD_TICK, 5'd0);
      // With the door opening the car holds its floor on a tick, and an
      // obstacle outside door closing is ignored.
      send_command(CMD_OPEN, 5'd31);
      send_command(CMD_TICK, 5'd0);
      send_command(CMD_OBSTACLE, 5'd0);
      // An obstacle while closing starts the countdown; a door command during
      // the countdown sets the mode but leaves the countdown running.
      send_command(CMD_CLOSE, 5'd0);
      send_command(CMD_OBSTACLE, 5'd31);
      send_command(CMD_TICK, 5'd0);
      send_command(CMD_OPEN, 5'd0);
      send_command(CMD_TICK, 5'd0);
      send_command(CMD_UNUSED, 5'd31);
      // Fire parks the car at the home floor; requests are still queued,
      // ticks do nothing, door commands do not unlock.
      send_command(CMD_FIRE, 5'd0);
      send_command(CMD_ADD, 5'd9);
      send_command(CMD_TICK, 5'd0);
      send_command(CMD_CLOSE, 5'd0);
      send_command(CMD_RESET, 5'd31);
      // An empty queue leaves the car idle; a request for the current floor
      // is dropped on the first tick without a step.
      send_command(CMD_TICK, 5'd0);
      send_command(CMD_ADD, 5'd1);
      send_command(CMD_TICK, 5'd0);

      // Random part, built from short scenarios that reach the deeper states.
      while (sent_total < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            // A few requests, mostly in range, then a run of ticks to travel.
            repeat ($urandom_range(1, 5))
               send_command(CMD_ADD,
                            ($urandom_range(0, 9) == 0) ? any_floor() : valid_floor());
            run_ticks($urandom_range(1, 40));
         end else if (pick < 40) begin
            // Fill the queue with every floor in random order, then push it
            // past full, then let the car work through part of the list.
            send_command(CMD_RESET, any_floor());
            for (int i = 0; i < MAX_FLOORS_DEF; i++) order[i] = FLOOR_W'(i + 1);
            for (int i = MAX_FLOORS_DEF - 1; i > 0; i--) begin
               j        = $urandom_range(0, i);
               swap     = order[i];
               order[i] = order[j];
               order[j] = swap;
            end
            for (int i = 0; i < MAX_FLOORS_DEF; i++) send_command(CMD_ADD, order[i]);
            repeat ($urandom_range(1, 3)) send_command(CMD_ADD, valid_floor());
            run_ticks($urandom_range(10, 60));
         end else if (pick < 58) begin
            // Door closing hit by an obstacle; most countdowns run to the
            // end so the car goes back to idle, some are cut short.
            if ($urandom_range(0, 3) == 0) send_command(CMD_ADD, valid_floor());
            send_command(CMD_CLOSE, any_floor());
            if ($urandom_range(0, 4) == 0) send_command(CMD_TICK, any_floor());
            send_command(CMD_OBSTACLE, any_floor());
            ticks = ($urandom_range(0, 9) < 7) ? $urandom_range(20, 24)
                                               : $urandom_range(0, 19);
            run_ticks(ticks);
         end else if (pick < 66) begin
            // Fire alarm, a few arbitrary commands under the lock, and
            // usually a reset to release the car.
            send_command(CMD_FIRE, any_floor());
            repeat ($urandom_range(0, 4))
               send_command(CMD_W'($urandom_range(0, 5)), any_floor());
            if ($urandom_range(0, 9) != 0) send_command(CMD_RESET, any_floor());
         end else begin
            // Noise: any code, any floor.
            send_command(CMD_W'($urandom_range(0, 7)), any_floor());
         end
      end
      start <= 1'b0;

      // Drain: every result must come back, then stray strobes are caught.
      while (awaited_total != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display({"Sent %0d commands: %0d ticks, %0d add requests, %0d door opens, ",
                "%0d door closes, %0d obstacles, %0d fire alarms, %0d resets, ",
                "%0d unused codes."},
               sent_total, sent_by_cmd[CMD_TICK], sent_by_cmd[CMD_ADD],
               sent_by_cmd[CMD_OPEN], sent_by_cmd[CMD_CLOSE], sent_by_cmd[CMD_OBSTACLE],
               sent_by_cmd[CMD_FIRE], sent_by_cmd[CMD_RESET], sent_by_cmd[CMD_UNUSED]);
      $display("Compared %0d results with the predicted car state, %0d mismatches.",
               results_total, mismatch_total);
      if (mismatch_total == 0 && awaited_total == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/elev_pkg.sv
rtl/elev_ctrl.sv
rtl/elev_dpath.sv
rtl/elevator_car_controller.sv
sim/elev_checker.sv
sim/tb_top.sv
